>>> design/two_level_page_walk_memory_macros.svh
// ----------------------------------------------------------------------------
// two_level_page_walk_memory_macros
// assertion shorthands used by the checker file of the page walk memory
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_PAGE_WALK_MEMORY_MACROS_SVH
`define TWO_LEVEL_PAGE_WALK_MEMORY_MACROS_SVH

// consequent checked in the same cycle
`define TLPW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define TLPW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/tlpw_pkg.sv
// ----------------------------------------------------------------------------
// tlpw_pkg
// types and constants of the two-level page walk memory
// ----------------------------------------------------------------------------
package tlpw_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int ADDR_W    = $clog2(MEM_BYTES);

    localparam logic [32:0] MEM_LIMIT  = 33'(MEM_BYTES);
    localparam logic [31:0] OFF_MASK   = 32'h0000_0fff;
    localparam logic [31:0] FRAME_MASK = ~OFF_MASK;
    localparam int          PAGE_SIZE  = 1 << 12;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NO_DIR = 2'd1,
        ST_NO_TAB = 2'd2,
        ST_RANGE  = 2'd3
    } status_t;

    typedef enum logic {
        REG_PAGING_ENABLE = 1'b0,
        REG_PAGE_DIR_BASE = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_ENT_RNG,
        S_ENT_RD,
        S_ENT_CHK,
        S_PA_CHK,
        S_NEXT,
        S_DATA,
        S_DONE
    } state_t;

endpackage

>>> design/tlpw_ram.sv
// ----------------------------------------------------------------------------
// tlpw_ram
// single-port ram, one read or write per cycle, registered read data
// ----------------------------------------------------------------------------
module tlpw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/two_level_page_walk_memory.sv
// ----------------------------------------------------------------------------
// two_level_page_walk_memory
// byte memory with 10/10/12 two-level page translation
// ----------------------------------------------------------------------------
// An access is taken when start is high and busy is low; the result shows on
// read_data and status for exactly one cycle with done high, and must be taken
// then. After reset the block sweeps the memory to zero, one byte a cycle, and
// holds busy until the sweep is through. Everything goes through one byte-wide
// memory port and one shared 32-bit adder: a table entry is read one byte a
// cycle. With paging on each access walks the tables, twice for an access that
// crosses a page; with paging off no table is read. A zero length goes straight
// to done. A fault ends the access before any byte is touched.
module two_level_page_walk_memory (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic        func,
    input  logic [31:0] vaddr,
    input  logic [31:0] write_data,
    input  logic [2:0]  access_len,
    output logic        done,
    output logic [31:0] read_data,
    output logic [1:0]  status
);

    import tlpw_pkg::*;

    state_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;

    logic        paging_enable_reg;
    logic [31:0] page_dir_base_reg;

    logic              func_reg, func_next;
    logic [31:0]       va_reg, va_next;
    logic [31:0]       wdata_reg, wdata_next;
    logic [31:0]       rdata_reg, rdata_next;
    logic [2:0]        len_reg, len_next;
    logic [2:0]        n1_reg, n1_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic              part_reg, part_next;
    logic              level_reg, level_next;
    logic [31:0]       addr_reg, addr_next;
    logic [31:0]       word_reg, word_next;
    logic [31:0]       p_reg, p_next;
    logic [ADDR_W-1:0] pa1_reg, pa1_next;
    logic [ADDR_W-1:0] pa2_reg, pa2_next;
    status_t           status_reg, status_next;

    // shared adder
    logic [31:0] add_a, add_b;
    logic [32:0] add_sum;

    logic              ram_en, ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_wdata, ram_rdata;

    logic [2:0]  len_sat, n1_in, part_len, data_off, cnt_m1;
    logic [12:0] off_ext;
    logic        crosses;

    assign add_sum = {1'b0, add_a} + {1'b0, add_b};

    assign len_sat  = (access_len > 3'd4) ? 3'd4 : access_len;
    assign off_ext  = {1'b0, vaddr[11:0]};
    assign crosses  = (off_ext + {10'd0, len_sat}) > 13'(PAGE_SIZE);
    assign n1_in    = crosses ? 3'(13'(PAGE_SIZE) - off_ext) : len_sat;
    assign part_len = part_reg ? (len_reg - n1_reg) : n1_reg;
    assign data_off = (cnt_reg < n1_reg) ? cnt_reg : (cnt_reg - n1_reg);
    assign cnt_m1   = cnt_reg - 3'd1;

    tlpw_ram #(
        .WIDTH(8),
        .DEPTH(MEM_BYTES)
    ) u_ram (
        .clk  (clk),
        .en   (ram_en),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            paging_enable_reg <= 1'b0;
            page_dir_base_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_PAGING_ENABLE: paging_enable_reg <= cfg_wdata[0];
                REG_PAGE_DIR_BASE: page_dir_base_reg <= cfg_wdata;
                default:           paging_enable_reg <= paging_enable_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        va_reg     <= va_next;
        wdata_reg  <= wdata_next;
        rdata_reg  <= rdata_next;
        len_reg    <= len_next;
        n1_reg     <= n1_next;
        cnt_reg    <= cnt_next;
        part_reg   <= part_next;
        level_reg  <= level_next;
        addr_reg   <= addr_next;
        word_reg   <= word_next;
        p_reg      <= p_next;
        pa1_reg    <= pa1_next;
        pa2_reg    <= pa2_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        func_next   = func_reg;
        va_next     = va_reg;
        wdata_next  = wdata_reg;
        rdata_next  = rdata_reg;
        len_next    = len_reg;
        n1_next     = n1_reg;
        cnt_next    = cnt_reg;
        part_next   = part_reg;
        level_next  = level_reg;
        addr_next   = addr_reg;
        word_next   = word_reg;
        p_next      = p_reg;
        pa1_next    = pa1_reg;
        pa2_next    = pa2_reg;
        status_next = status_reg;
        add_a       = '0;
        add_b       = '0;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = add_sum[ADDR_W-1:0];
        ram_wdata   = 8'h00;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_en   = 1'b1;
                ram_we   = 1'b1;
                ram_addr = clr_reg;
                if (clr_reg == ADDR_W'(MEM_BYTES - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + ADDR_W'(1);
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    func_next   = func;
                    va_next     = vaddr;
                    wdata_next  = write_data;
                    rdata_next  = '0;
                    status_next = ST_OK;
                    len_next    = len_sat;
                    n1_next     = n1_in;
                    part_next   = 1'b0;
                    level_next  = 1'b0;
                    state_next  = (access_len == 3'd0) ? S_DONE : S_WALK;
                end
            end
            S_WALK:
            begin
                add_a = page_dir_base_reg & FRAME_MASK;
                add_b = {20'd0, va_reg[31:22], 2'b00};
                if (paging_enable_reg)
                begin
                    addr_next  = add_sum[31:0];
                    level_next = 1'b0;
                    state_next = S_ENT_RNG;
                end
                else
                begin
                    p_next     = va_reg;
                    state_next = S_PA_CHK;
                end
            end
            S_ENT_RNG:
            begin
                add_a = addr_reg;
                add_b = 32'd4;
                if (add_sum > MEM_LIMIT)
                begin
                    status_next = ST_RANGE;
                    state_next  = S_DONE;
                end
                else
                begin
                    cnt_next   = 3'd0;
                    state_next = S_ENT_RD;
                end
            end
            S_ENT_RD:
            begin
                // issue byte cnt, collect byte cnt-1 from the ram
                add_a = addr_reg;
                add_b = {29'd0, cnt_reg};
                if (cnt_reg != 3'd4)
                begin
                    ram_en = 1'b1;
                end
                if (cnt_reg != 3'd0)
                begin
                    word_next = {ram_rdata, word_reg[31:8]};
                end
                if (cnt_reg == 3'd4)
                begin
                    state_next = S_ENT_CHK;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            S_ENT_CHK:
            begin
                add_a = word_reg & FRAME_MASK;
                add_b = {20'd0, va_reg[21:12], 2'b00};
                if (!word_reg[0])
                begin
                    status_next = level_reg ? ST_NO_TAB : ST_NO_DIR;
                    state_next  = S_DONE;
                end
                else if (!level_reg)
                begin
                    addr_next  = add_sum[31:0];
                    level_next = 1'b1;
                    state_next = S_ENT_RNG;
                end
                else
                begin
                    p_next     = (word_reg & FRAME_MASK) | (va_reg & OFF_MASK);
                    state_next = S_PA_CHK;
                end
            end
            S_PA_CHK:
            begin
                add_a = p_reg;
                add_b = {29'd0, part_len};
                if (add_sum > MEM_LIMIT)
                begin
                    status_next = ST_RANGE;
                    state_next  = S_DONE;
                end
                else if (!part_reg)
                begin
                    pa1_next = p_reg[ADDR_W-1:0];
                    cnt_next = 3'd0;
                    state_next = (n1_reg != len_reg) ? S_NEXT : S_DATA;
                end
                else
                begin
                    pa2_next   = p_reg[ADDR_W-1:0];
                    cnt_next   = 3'd0;
                    state_next = S_DATA;
                end
            end
            S_NEXT:
            begin
                // second part starts on the next page
                add_a      = va_reg;
                add_b      = {29'd0, n1_reg};
                va_next    = add_sum[31:0];
                part_next  = 1'b1;
                state_next = S_WALK;
            end
            S_DATA:
            begin
                add_a = (cnt_reg < n1_reg) ? 32'(pa1_reg) : 32'(pa2_reg);
                add_b = {29'd0, data_off};
                if (cnt_reg != len_reg)
                begin
                    ram_en     = 1'b1;
                    ram_we     = func_reg;
                    ram_wdata  = wdata_reg[7:0];
                    wdata_next = wdata_reg >> 8;
                end
                if (cnt_reg != 3'd0 && !func_reg)
                begin
                    rdata_next[{cnt_m1[1:0], 3'b000} +: 8] = ram_rdata;
                end
                if (cnt_reg == len_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = (state_reg == S_DONE);
    assign read_data = rdata_reg;
    assign status    = status_reg;

endmodule

>>> design/tlpw_checker.sv
// ----------------------------------------------------------------------------
// tlpw_checker
// port-level checks of the two-level page walk memory
// ----------------------------------------------------------------------------
`include "two_level_page_walk_memory_macros.svh"

module tlpw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [31:0] read_data,
    input logic [1:0]  status
);

    import tlpw_pkg::*;

    // an accepted access makes the block busy in the next cycle
    `TLPW_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accept without busy")

    // no result while idle
    `TLPW_ASSERT_NOW(a_done_busy, clk, rst_n, done, busy, "done while idle")

    `TLPW_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done, "done longer than one cycle")

    // a fault returns no data
    `TLPW_ASSERT_NOW(a_fault_zero, clk, rst_n, done && status != ST_OK, read_data == 32'd0, "fault with data")

endmodule

bind two_level_page_walk_memory tlpw_checker u_tlpw_checker (.*);
